[hw/rtl/tgadec_pkg.sv]
// Shared types, constants and helpers for the TGA run-length pixel decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tgadec_pkg;

  localparam int unsigned MaxBytes = 4;                 // largest pixel in bytes
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PixW     = 32;
  localparam int unsigned NumLanes = PixW / ByteW;      // bytes kept per pixel
  localparam int unsigned SlotW    = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
  localparam int unsigned SlotCntW = SlotW + 1;         // byte count up to MaxBytes
  localparam int unsigned BppW     = 3;
  localparam int unsigned DimW     = 16;
  localparam int unsigned TotalW   = 2 * DimW;
  localparam int unsigned CountW   = 8;                 // packet pixel count, 1..128
  localparam int unsigned RunCap   = 64;                // pixels per item, at most
  localparam int unsigned BurstW   = $clog2(RunCap);
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned BppReset = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BPP    = 8'd0,
    CFG_WIDTH  = 8'd1,
    CFG_HEIGHT = 8'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT_RUN,
    S_EMIT_LEFT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,       // image complete: drop packet state
    OP_HEADER,      // take byte as packet header
    OP_PIX_PART,    // store a pixel byte, pixel not yet complete
    OP_PIX_RAW,     // last byte of a literal pixel: store and emit it
    OP_PIX_RUN,     // last byte of a run pixel: store, start the burst
    OP_LEFT_START,  // hold the byte, repeat what is left of a long run first
    OP_EMIT         // one repeated pixel into the output register
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   left;   // burst is a run leftover; held byte becomes the header
  } dp_cmd_t;

  typedef struct packed {
    logic done;        // image complete
    logic leftover;    // long run still has pixels pending
    logic in_pkt;      // expecting pixel bytes
    logic pix_done;    // incoming byte completes a pixel
    logic run_flag;
    logic burst_last;  // pixel now emitted ends the burst
    logic out_free;    // output register can take a pixel this cycle
  } dp_stat_t;

  // Pixel size clamped to 1..MaxBytes.
  function automatic logic [SlotCntW-1:0] eff_bpp(input logic [BppW-1:0] bpp);
    logic [SlotCntW-1:0] res;
    if (bpp == '0) begin
      res = SlotCntW'(1);
    end else if (int'(bpp) > int'(MaxBytes)) begin
      res = SlotCntW'(MaxBytes);
    end else begin
      res = SlotCntW'(bpp);
    end
    return res;
  endfunction

endpackage

[hw/rtl/tgadec_cfg.sv]
// Configuration registers of the TGA decoder and the registered pixel total.
// Depends on tgadec_pkg.
`timescale 1ns / 1ps

module tgadec_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tgadec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tgadec_pkg::DimW-1:0]    cfg_data_i,
  output logic [tgadec_pkg::BppW-1:0]    bpp_o,
  output logic [tgadec_pkg::TotalW-1:0]  total_o,
  output logic                           busy_o
);
  import tgadec_pkg::*;

  logic [BppW-1:0]   bpp_q, bpp_d;
  logic [DimW-1:0]   width_q, width_d;
  logic [DimW-1:0]   height_q, height_d;
  logic [TotalW-1:0] total_q;
  logic              busy_q;
  logic              wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    if (wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BPP:    bpp_d    = cfg_data_i[BppW-1:0];
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        default:    ;
      endcase
    end
  end

  // total is registered off the size registers, so it lags them; busy covers the write and that lag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BppW'(BppReset);
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      total_q  <= TotalW'(1);
      busy_q   <= 1'b0;
    end else begin
      bpp_q    <= bpp_d;
      width_q  <= width_d;
      height_q <= height_d;
      total_q  <= TotalW'(width_q) * TotalW'(height_q);
      busy_q   <= wr;
    end
  end

  assign bpp_o   = bpp_q;
  assign total_o = total_q;
  assign busy_o  = busy_q | wr;

endmodule

[hw/rtl/tgadec_dp.sv]
// Datapath of the TGA decoder: packet state, pixel assembly, counters and
// the output register. Driven by tgadec_ctrl; depends on tgadec_pkg.
`timescale 1ns / 1ps

module tgadec_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tgadec_pkg::dp_cmd_t           cmd_i,
  output tgadec_pkg::dp_stat_t          stat_o,
  input  logic [tgadec_pkg::BppW-1:0]   bpp_i,
  input  logic [tgadec_pkg::TotalW-1:0] total_i,
  input  logic [tgadec_pkg::ByteW-1:0]  byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tgadec_pkg::PixW-1:0]   pixel_value_o,
  output logic                          run_last_o,
  output logic                          image_last_o
);
  import tgadec_pkg::*;

  logic                in_pkt_q, in_pkt_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic                run_q, run_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [PixW-1:0]     asm_q, asm_d;
  logic [TotalW-1:0]   emitted_q, emitted_d;
  logic [ByteW-1:0]    hold_q, hold_d;
  logic [BurstW-1:0]   burst_q, burst_d;
  logic                out_valid_q, out_valid_d;
  logic [PixW-1:0]     out_pix_q, out_pix_d;
  logic                out_rl_q, out_rl_d;
  logic                out_il_q, out_il_d;

  logic [PixW-1:0]     asm_new;
  logic [SlotCntW-1:0] slot_inc;
  logic                done, emit_last, burst_last, out_free;
  logic                load;
  logic [PixW-1:0]     load_pix;
  logic                load_rl;

  function automatic logic [CountW-1:0] pkt_count(input logic [ByteW-1:0] b);
    return CountW'(b[6:0]) + CountW'(1);
  endfunction

  assign done       = emitted_q >= total_i;
  assign emit_last  = (emitted_q + TotalW'(1)) == total_i;
  assign burst_last = (rem_q == CountW'(1)) || (&burst_q) || emit_last;
  assign out_free   = !out_valid_q || out_ready_i;
  assign slot_inc   = SlotCntW'(slot_q) + SlotCntW'(1);

  // little-endian byte lanes; first byte of a pixel clears the rest
  always_comb begin
    asm_new = (slot_q == '0) ? '0 : asm_q;
    for (int i = 0; i < int'(NumLanes); i++) begin
      if (int'(slot_q) == i) begin
        asm_new[i*ByteW +: ByteW] = byte_i;
      end
    end
  end

  always_comb begin
    stat_o.done       = done;
    stat_o.leftover   = !in_pkt_q && run_q && (rem_q != '0);
    stat_o.in_pkt     = in_pkt_q;
    stat_o.pix_done   = slot_inc >= eff_bpp(bpp_i);
    stat_o.run_flag   = run_q;
    stat_o.burst_last = burst_last;
    stat_o.out_free   = out_free;
  end

  always_comb begin
    in_pkt_d  = in_pkt_q;
    rem_d     = rem_q;
    run_d     = run_q;
    slot_d    = slot_q;
    asm_d     = asm_q;
    emitted_d = emitted_q;
    hold_d    = hold_q;
    burst_d   = burst_q;
    load      = 1'b0;
    load_pix  = asm_q;
    load_rl   = 1'b0;
    case (cmd_i.op)
      OP_CLEAR: begin
        in_pkt_d = 1'b0;
        rem_d    = '0;
        run_d    = 1'b0;
        slot_d   = '0;
      end
      OP_HEADER: begin
        rem_d    = pkt_count(byte_i);
        run_d    = byte_i[ByteW-1];
        slot_d   = '0;
        in_pkt_d = 1'b1;
      end
      OP_PIX_PART: begin
        asm_d  = asm_new;
        slot_d = slot_inc[SlotW-1:0];
      end
      OP_PIX_RAW: begin
        asm_d     = asm_new;
        slot_d    = '0;
        load      = 1'b1;
        load_pix  = asm_new;
        load_rl   = 1'b1;
        emitted_d = emitted_q + TotalW'(1);
        if (emit_last) begin
          in_pkt_d = 1'b0;
          rem_d    = '0;
          run_d    = 1'b0;
        end else begin
          rem_d = rem_q - CountW'(1);
          if (rem_q == CountW'(1)) begin
            in_pkt_d = 1'b0;
          end
        end
      end
      OP_PIX_RUN: begin
        asm_d   = asm_new;
        slot_d  = '0;
        burst_d = '0;
      end
      OP_LEFT_START: begin
        hold_d  = byte_i;
        burst_d = '0;
      end
      OP_EMIT: begin
        load      = 1'b1;
        load_rl   = burst_last;
        emitted_d = emitted_q + TotalW'(1);
        burst_d   = burst_q + BurstW'(1);
        rem_d     = rem_q - CountW'(1);
        if (burst_last) begin
          if (emit_last) begin
            in_pkt_d = 1'b0;
            rem_d    = '0;
            run_d    = 1'b0;
            slot_d   = '0;
          end else if (cmd_i.left) begin
            // leftover done: held byte is the next header
            rem_d    = pkt_count(hold_q);
            run_d    = hold_q[ByteW-1];
            slot_d   = '0;
            in_pkt_d = 1'b1;
          end else begin
            in_pkt_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_rl_d    = out_rl_q;
    out_il_d    = out_il_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_pix_d   = load_pix;
      out_rl_d    = load_rl;
      out_il_d    = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q    <= 1'b0;
      rem_q       <= '0;
      run_q       <= 1'b0;
      slot_q      <= '0;
      asm_q       <= '0;
      emitted_q   <= '0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_pkt_q    <= in_pkt_d;
      rem_q       <= rem_d;
      run_q       <= run_d;
      slot_q      <= slot_d;
      asm_q       <= asm_d;
      emitted_q   <= emitted_d;
      burst_q     <= burst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q    <= hold_d;
    out_pix_q <= out_pix_d;
    out_rl_q  <= out_rl_d;
    out_il_q  <= out_il_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_pix_q;
  assign run_last_o    = out_rl_q;
  assign image_last_o  = out_il_q;

`ifndef ASSERT_OFF
  a_no_emit_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !done)
    else $error("pixel emitted after image complete");

  a_burst_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> (rem_q != '0))
    else $error("repeat burst with no pixels left");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("output register overwritten");

  a_image_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_il_q) |-> out_rl_q)
    else $error("final image pixel not flagged as last of item");
`endif

endmodule

[hw/rtl/tgadec_ctrl.sv]
// Controller of the TGA decoder: sequences header, pixel and repeat phases.
// Talks to tgadec_dp through command/status structs; depends on tgadec_pkg.
`timescale 1ns / 1ps

module tgadec_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cfg_busy_i,
  input  tgadec_pkg::dp_stat_t stat_i,
  output tgadec_pkg::dp_cmd_t  cmd_o
);
  import tgadec_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !stat_i.done) begin
          if (stat_i.leftover) begin
            state_d = S_EMIT_LEFT;
          end else if (stat_i.in_pkt && stat_i.pix_done && stat_i.run_flag) begin
            state_d = S_EMIT_RUN;
          end
        end
      end
      S_EMIT_RUN, S_EMIT_LEFT: begin
        if (stat_i.out_free && stat_i.burst_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.left = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free && !cfg_busy_i;
        if (in_valid_i && stat_i.out_free && !cfg_busy_i) begin
          if (stat_i.done) begin
            cmd_o.op = OP_CLEAR;
          end else if (stat_i.leftover) begin
            cmd_o.op = OP_LEFT_START;
          end else if (!stat_i.in_pkt) begin
            cmd_o.op = OP_HEADER;
          end else if (!stat_i.pix_done) begin
            cmd_o.op = OP_PIX_PART;
          end else if (stat_i.run_flag) begin
            cmd_o.op = OP_PIX_RUN;
          end else begin
            cmd_o.op = OP_PIX_RAW;
          end
        end
      end
      S_EMIT_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
        end
      end
      S_EMIT_LEFT: begin
        cmd_o.left = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/tga_rle_pixel_decoder.sv]
// TGA run-length pixel decoder. Takes the encoded pixel stream one byte per
// item and returns decoded pixels, first stream byte in bits 7:0. The
// last byte of a literal pixel is taken and its pixel lands in the output
// register in that same cycle, so literal data streams at one byte per
// cycle while the output side takes pixels. The last byte of a run pixel
// starts a repeat burst: the input stalls while the output register is
// loaded once per cycle as the output side frees it, up to 64 pixels per
// item. A run longer than 64 leaves the rest pending; they go out ahead of
// the next byte, which is then taken as a header. The input is also held off
// in the cycle of a configuration write and in the cycle after it, while the
// pixel total (width * height, one registered multiply) settles. run_last_o
// marks the last pixel caused by one input byte; image_last_o marks pixel
// number width*height, after which bytes are swallowed until the image
// size grows.
// Depends on tgadec_pkg, tgadec_cfg, tgadec_ctrl and tgadec_dp.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes: index 0 pixel bytes, 1 width, 2 height
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tgadec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tgadec_pkg::DimW-1:0]    cfg_data_i,
  // encoded byte stream
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tgadec_pkg::ByteW-1:0]   stream_byte_i,
  // decoded pixels
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tgadec_pkg::PixW-1:0]    pixel_value_o,
  output logic                           run_last_o,
  output logic                           image_last_o
);
  import tgadec_pkg::*;

  logic [BppW-1:0]   bpp;
  logic [TotalW-1:0] total;
  logic              cfg_busy;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // register file; total is registered off width and height
  tgadec_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bpp_o       (bpp),
    .total_o     (total),
    .busy_o      (cfg_busy)
  );

  // decides what each byte is and when repeat bursts run
  tgadec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cfg_busy_i (cfg_busy),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // packet state, pixel assembly, pixel count and output register
  tgadec_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .bpp_i         (bpp),
    .total_i       (total),
    .byte_i        (stream_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .run_last_o    (run_last_o),
    .image_last_o  (image_last_o)
  );

endmodule
